/* src/rv32_pkg.sv */
// Package for the RV32I execute core: opcodes, error codes, stream packing widths.
// No dependencies.
package rv32_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int WADDR_W   = $clog2(MEM_WORDS);
    localparam int BADDR_W   = $clog2(MEM_BYTES);

    localparam int IN_W  = 80;   // instr, load_addr, load_data, padded
    localparam int OUT_W = 80;   // pc_next, rd_index, rd_value, rd_written, store_done, error, padded

    typedef enum logic [6:0] {
        OP_REG    = 7'h33,
        OP_IMM    = 7'h13,
        OP_LUI    = 7'h37,
        OP_AUIPC  = 7'h17,
        OP_JAL    = 7'h6F,
        OP_JALR   = 7'h67,
        OP_BRANCH = 7'h63,
        OP_LOAD   = 7'h03,
        OP_STORE  = 7'h23,
        OP_FENCE  = 7'h0F,
        OP_SYSTEM = 7'h73
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_OPCODE = 2'd1,
        ERR_RANGE  = 2'd2
    } err_t;

    typedef enum logic {
        CMD_EXEC    = 1'b0,
        CMD_PRELOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [31:0] pc_next;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic        rd_written;
        logic        store_done;
        logic [1:0]  error;
    } result_t;

    // Control from the decode/execute logic to the state holder.
    typedef struct packed {
        logic              pc_we;
        logic [31:0]       pc_val;
        logic              rf_we;
        logic [4:0]        rf_idx;
        logic [31:0]       rf_val;
        logic              mem_we;
        logic [WADDR_W-1:0] mem_widx;
        logic [63:0]       mem_wdata;  // two words, for stores spanning a word boundary
        logic [7:0]        mem_wbe;
        logic              ld_we;      // load result written back in the cycle after commit
        logic [2:0]        ld_f3;
        logic [1:0]        ld_boff;
    } commit_t;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        case (f3)
            3'd0: r = alt ? a - b : a + b;
            3'd1: r = a << b[4:0];
            3'd2: r = {31'd0, $signed(a) < $signed(b)};
            3'd3: r = {31'd0, a < b};
            3'd4: r = a ^ b;
            3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

    // Align and extend load data taken from the two words at the access.
    function automatic logic [31:0] load_value(input logic [2:0] f3, input logic [1:0] boff,
                                               input logic [63:0] data);
        logic [63:0] s;
        logic [31:0] r;
        s = data >> {boff, 3'b000};
        case (f3)
            3'd0: r = {{24{s[7]}}, s[7:0]};
            3'd1: r = {{16{s[15]}}, s[15:0]};
            3'd4: r = {24'd0, s[7:0]};
            3'd5: r = {16'd0, s[15:0]};
            default: r = s[31:0];
        endcase
        return r;
    endfunction

endpackage

/* src/rv32i_execute_core_unit.sv */
// Top level of the RV32I execute core: input register, execute, state, output register.
// Depends on rv32_pkg, rv32_exec, rv32_state.
//
// Usage:
//   s_axis carries one item per handshake: cmd in tuser, and tdata holds
//   instr [31:0], load_addr [43:32], load_data [75:44].
//   m_axis returns one result item per input item, in order.
//   cfg_we/cfg_data write start_pc and load the PC; write only while idle.
// Flow: an accepted item is executed from the input register against the
// architectural state once the output register is empty or being drained;
// its result is registered at the end of that cycle.
// Load data is read from memory at the commit edge and aligned on the way
// out of the output register.
// Throughput: one item per cycle unless m_axis stalls. A loaded value is
// forwarded to the next item from the registered read data and then lands in
// the register file; all other state updates are visible to the next item.
// Stall: the input register moves only when the output register is empty
// or being drained, so s_axis_tready drops at once when m_axis stalls with
// both registers full; nothing is lost.
// Reset: PC reads 0, registers x1..x31 zero, no items in flight. The data
// memory is undefined until written by preload or a store.
module rv32i_execute_core_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [rv32_pkg::IN_W-1:0]  s_axis_tdata,   // instr, load_addr, load_data, pad
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [rv32_pkg::OUT_W-1:0] m_axis_tdata    // pc_next, rd_index, rd_value,
                                                       // rd_written, store_done, error, pad
);
    import rv32_pkg::*;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [75:0] in_data_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_load_reg;
    logic [2:0]  out_f3_reg;
    logic [1:0]  out_boff_reg;
    logic        ld_pend_reg;
    logic [31:0] ld_val;
    logic [31:0] rd_value_out;
    logic        advance;
    logic [31:0] pc, rs1_val, rs2_val;
    logic [63:0] mem_rdata;
    logic [WADDR_W-1:0] mem_ridx;
    commit_t     commit;
    result_t     result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[75:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg      <= result;
            out_load_reg <= commit.ld_we;
            out_f3_reg   <= commit.ld_f3;
            out_boff_reg <= commit.ld_boff;
        end
    end

    // Pending load writeback, raised in the cycle after its commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_pend_reg <= 1'b0;
        else
            ld_pend_reg <= advance && commit.ld_we;
    end

    assign ld_val       = load_value(out_f3_reg, out_boff_reg, mem_rdata);
    assign rd_value_out = out_load_reg ? ld_val : out_reg.rd_value;

    rv32_exec u_exec (
        .cmd       (in_cmd_reg),
        .instr     (in_data_reg[31:0]),
        .load_addr (in_data_reg[43:32]),
        .load_data (in_data_reg[75:44]),
        .pc        (pc),
        .rs1_val   (rs1_val),
        .rs2_val   (rs2_val),
        .mem_ridx  (mem_ridx),
        .commit    (commit),
        .result    (result)
    );

    rv32_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .commit_en (advance),
        .commit    (commit),
        .ld_we     (ld_pend_reg),
        .ld_idx    (out_reg.rd_index),
        .ld_val    (ld_val),
        .rs1_idx   (in_data_reg[19:15]),
        .rs2_idx   (in_data_reg[24:20]),
        .mem_ridx  (mem_ridx),
        .pc        (pc),
        .rs1_val   (rs1_val),
        .rs2_val   (rs2_val),
        .mem_rdata (mem_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.error, out_reg.store_done, out_reg.rd_written,
                            rd_value_out, out_reg.rd_index, out_reg.pc_next};

    // A result is never dropped while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg)
        else $error("result lost under stall");

    // x0 is never reported as written.
    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(result.rd_written && result.rd_index == 5'd0))
        else $error("write to x0");

    // A failed item leaves no side effect.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.error != ERR_NONE |-> !commit.rf_we && !result.store_done)
        else $error("state changed on error");

endmodule

/* src/rv32_exec.sv */
// Combinational execute stage: decode, ALU, branch, address and data alignment.
// Depends on rv32_pkg.
module rv32_exec (
    input  logic                      cmd,
    input  logic [31:0]               instr,
    input  logic [11:0]               load_addr,
    input  logic [31:0]               load_data,
    input  logic [31:0]               pc,
    input  logic [31:0]               rs1_val,
    input  logic [31:0]               rs2_val,
    output logic [rv32_pkg::WADDR_W-1:0] mem_ridx,
    output rv32_pkg::commit_t         commit,
    output rv32_pkg::result_t         result
);
    import rv32_pkg::*;

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, upper;
    logic [31:0] addr, wval, next, pc4, sdata;
    logic [32:0] addr_end;
    logic [2:0]  nbytes;
    logic        wr, st, mem_acc, ld;
    err_t        err;
    logic [127:0] wide;
    logic [7:0]  be;
    logic [1:0]  boff;

    assign op    = instr[6:0];
    assign rd    = instr[11:7];
    assign f3    = instr[14:12];
    assign alt   = instr[30];
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign upper = {instr[31:12], 12'd0};
    assign pc4   = pc + 32'd4;

    always_comb
    begin
        if (cmd == CMD_PRELOAD)
            addr = {20'd0, load_addr};
        else if (op == OP_STORE)
            addr = rs1_val + imm_s;
        else
            addr = rs1_val + imm_i;
    end

    assign mem_ridx = addr[BADDR_W-1:2];
    assign boff     = addr[1:0];

    always_comb
    begin
        if (cmd == CMD_PRELOAD)
            nbytes = 3'd4;
        else
            case (f3[1:0])
                2'd0: nbytes = 3'd1;
                2'd1: nbytes = 3'd2;
                default: nbytes = 3'd4;
            endcase
        addr_end = {1'b0, addr} + {30'd0, nbytes};
    end

    always_comb
    begin
        next    = pc4;
        wval    = 32'd0;
        wr      = 1'b0;
        st      = 1'b0;
        ld      = 1'b0;
        err     = ERR_NONE;
        mem_acc = 1'b0;
        sdata   = rs2_val;
        if (cmd == CMD_PRELOAD)
        begin
            next  = pc;
            sdata = load_data;
            mem_acc = 1'b1;
            if (addr_end > 33'(MEM_BYTES))
                err = ERR_RANGE;
            else
                st = 1'b1;
        end
        else
        begin
            case (op)
                OP_REG:    begin wr = 1'b1; wval = alu(f3, alt, rs1_val, rs2_val); end
                OP_IMM:
                begin
                    wr = 1'b1;
                    if (f3 == 3'd1 || f3 == 3'd5)
                        wval = alu(f3, alt, rs1_val, {27'd0, imm_i[4:0]});
                    else
                        wval = alu(f3, 1'b0, rs1_val, imm_i);
                end
                OP_LUI:    begin wr = 1'b1; wval = upper; end
                OP_AUIPC:  begin wr = 1'b1; wval = pc + upper; end
                OP_JAL:    begin wr = 1'b1; wval = pc4; next = pc + imm_j; end
                OP_JALR:
                begin
                    wr = 1'b1;
                    wval = pc4;
                    next = (rs1_val + imm_i) & 32'hFFFF_FFFE;
                end
                OP_BRANCH:
                begin
                    case (f3)
                        3'd0: if (rs1_val == rs2_val) next = pc + imm_b;
                        3'd1: if (rs1_val != rs2_val) next = pc + imm_b;
                        3'd4: if ($signed(rs1_val) < $signed(rs2_val)) next = pc + imm_b;
                        3'd5: if ($signed(rs1_val) >= $signed(rs2_val)) next = pc + imm_b;
                        3'd6: if (rs1_val < rs2_val) next = pc + imm_b;
                        3'd7: if (rs1_val >= rs2_val) next = pc + imm_b;
                        default: ;
                    endcase
                end
                OP_LOAD:
                begin
                    if (!(f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7))
                    begin
                        if (addr_end > 33'(MEM_BYTES))
                            err = ERR_RANGE;
                        else
                        begin
                            // data arrives from the registered memory read
                            wr = 1'b1;
                            ld = 1'b1;
                        end
                    end
                end
                OP_STORE:
                begin
                    if (f3 <= 3'd2)
                    begin
                        mem_acc = 1'b1;
                        if (addr_end > 33'(MEM_BYTES))
                            err = ERR_RANGE;
                        else
                            st = 1'b1;
                    end
                end
                OP_FENCE, OP_SYSTEM: ;
                default: err = ERR_OPCODE;
            endcase
            if (err != ERR_NONE)
            begin
                next = pc;
                wr   = 1'b0;
            end
            if (rd == 5'd0)
                wr = 1'b0;
        end
    end

    always_comb
    begin
        case (nbytes)
            3'd1: be = 8'b0000_0001 << boff;
            3'd2: be = 8'b0000_0011 << boff;
            default: be = 8'b0000_1111 << boff;
        endcase
        wide = {96'd0, sdata} << {boff, 3'b000};
    end

    always_comb
    begin
        commit.pc_we     = (cmd == CMD_EXEC);
        commit.pc_val    = next;
        commit.rf_we     = wr & ~ld;
        commit.rf_idx    = rd;
        commit.rf_val    = wval;
        commit.mem_we    = st & mem_acc;
        commit.mem_widx  = mem_ridx;
        commit.mem_wdata = wide[63:0];
        commit.mem_wbe   = be;
        commit.ld_we     = wr & ld;
        commit.ld_f3     = f3;
        commit.ld_boff   = boff;
        result.pc_next    = next;
        result.rd_index   = wr ? rd : 5'd0;
        result.rd_value   = wr ? wval : 32'd0;
        result.rd_written = wr;
        result.store_done = st;
        result.error      = err;
    end

endmodule

/* src/rv32_state.sv */
// Architectural state: PC, register file, byte-lane data memory split in even/odd words.
// Depends on rv32_pkg.
module rv32_state (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [31:0]                  cfg_data,
    input  logic                         commit_en,
    input  rv32_pkg::commit_t            commit,
    input  logic                         ld_we,
    input  logic [4:0]                   ld_idx,
    input  logic [31:0]                  ld_val,
    input  logic [4:0]                   rs1_idx,
    input  logic [4:0]                   rs2_idx,
    input  logic [rv32_pkg::WADDR_W-1:0] mem_ridx,
    output logic [31:0]                  pc,
    output logic [31:0]                  rs1_val,
    output logic [31:0]                  rs2_val,
    output logic [63:0]                  mem_rdata
);
    import rv32_pkg::*;

    localparam int HALF   = MEM_WORDS / 2;
    localparam int HIDX_W = WADDR_W - 1;

    logic [31:0] pc_reg;
    logic [31:0] rf_reg [1:31];
    // Words at even and odd word addresses, so an access spanning two words
    // touches each bank once.
    logic [7:0]  mem_even [0:3][0:HALF-1];
    logic [7:0]  mem_odd  [0:3][0:HALF-1];

    logic [WADDR_W-1:0] r_next;
    logic [HIDX_W-1:0]  re_idx, ro_idx, we_idx, wo_idx;
    logic [31:0]        even_q_reg, odd_q_reg;
    logic               r_odd, w_odd, r_odd_reg;
    logic [WADDR_W-1:0] w_next;
    logic [3:0]         be_even, be_odd;
    logic [31:0]        wd_even, wd_odd;

    assign pc = pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= 32'd0;
        else if (cfg_we)
            pc_reg <= cfg_data;
        else if (commit_en && commit.pc_we)
            pc_reg <= commit.pc_val;
    end

    // Load data lands in the cycle after its item commits; a later item's own
    // write to the same register wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i < 32; i++)
                rf_reg[i] <= 32'd0;
        end
        else
        begin
            for (int i = 1; i < 32; i++)
            begin
                if (commit_en && commit.rf_we && commit.rf_idx == 5'(i))
                    rf_reg[i] <= commit.rf_val;
                else if (ld_we && ld_idx == 5'(i))
                    rf_reg[i] <= ld_val;
            end
        end
    end

    assign rs1_val = (rs1_idx == 5'd0) ? 32'd0 :
                     (ld_we && ld_idx == rs1_idx) ? ld_val : rf_reg[rs1_idx];
    assign rs2_val = (rs2_idx == 5'd0) ? 32'd0 :
                     (ld_we && ld_idx == rs2_idx) ? ld_val : rf_reg[rs2_idx];

    // Read: word at mem_ridx and the one after, registered at the commit edge.
    assign r_odd  = mem_ridx[0];
    assign r_next = mem_ridx + WADDR_W'(1);
    assign re_idx = r_odd ? r_next[WADDR_W-1:1] : mem_ridx[WADDR_W-1:1];
    assign ro_idx = mem_ridx[WADDR_W-1:1];

    always_ff @(posedge clk)
    begin
        if (commit_en)
        begin
            for (int b = 0; b < 4; b++)
            begin
                even_q_reg[8*b +: 8] <= mem_even[b][re_idx];
                odd_q_reg[8*b +: 8]  <= mem_odd[b][ro_idx];
            end
            r_odd_reg <= r_odd;
        end
    end

    assign mem_rdata = r_odd_reg ? {even_q_reg, odd_q_reg} : {odd_q_reg, even_q_reg};

    assign w_odd   = commit.mem_widx[0];
    assign w_next  = commit.mem_widx + WADDR_W'(1);
    assign we_idx  = w_odd ? w_next[WADDR_W-1:1] : commit.mem_widx[WADDR_W-1:1];
    assign wo_idx  = commit.mem_widx[WADDR_W-1:1];
    assign be_even = w_odd ? commit.mem_wbe[7:4] : commit.mem_wbe[3:0];
    assign be_odd  = w_odd ? commit.mem_wbe[3:0] : commit.mem_wbe[7:4];
    assign wd_even = w_odd ? commit.mem_wdata[63:32] : commit.mem_wdata[31:0];
    assign wd_odd  = w_odd ? commit.mem_wdata[31:0] : commit.mem_wdata[63:32];

    always_ff @(posedge clk)
    begin
        if (commit_en && commit.mem_we)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (be_even[b])
                    mem_even[b][we_idx] <= wd_even[8*b +: 8];
                if (be_odd[b])
                    mem_odd[b][wo_idx] <= wd_odd[8*b +: 8];
            end
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for rv32i_execute_core_unit: directed RV32I items, then
// random instruction streams checked against an in-bench model of the core.
// Depends on rv32_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
    import rv32_pkg::*;

    typedef struct {
        logic        cmd;
        logic [31:0] instr;
        logic [11:0] addr;
        logic [31:0] data;
    } item_t;

    typedef struct {
        logic [31:0] pc_next;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic        rd_written;
        logic        store_done;
        logic [1:0]  error;
    } retire_t;

    typedef struct {
        item_t   it;
        logic    typed;
        retire_t res;
    } row_t;

    localparam int WATCHDOG = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // instr, load_addr, load_data, pad
    logic        s_axis_tuser = 1'b0; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;       // pc_next, rd_index, rd_value, rd_written,
                                     // store_done, error, pad

    // model state of the core
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [32];
    logic [7:0]  arch_mem [MEM_BYTES];
    bit          mem_known [MEM_BYTES];

    retire_t pending_results [$];
    row_t    directed_rows [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      quiet_cycles = 0;

    rv32i_execute_core_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- instruction encoders ----------------
    function automatic logic [31:0] enc_r(opcode_t op, logic [4:0] rd, logic [2:0] f3,
                                          logic [4:0] rs1, logic [4:0] rs2, logic [6:0] f7);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(opcode_t op, logic [4:0] rd, logic [2:0] f3,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    function automatic logic [31:0] enc_u(opcode_t op, logic [4:0] rd, logic [19:0] imm);
        return {imm, rd, op};
    endfunction

    // ---------------- core model ----------------
    function automatic bit fits(logic [31:0] addr, int n);
        return ({1'b0, addr} + 33'(n)) <= 33'(MEM_BYTES);
    endfunction

    function automatic int access_bytes(logic [2:0] f3);
        return (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
    endfunction

    // true when the item would load a byte that was never written
    function automatic bit touches_unknown(item_t it);
        logic [31:0] addr;
        logic [2:0]  f3;
        int          n;
        f3 = it.instr[14:12];
        if (it.cmd != CMD_EXEC || it.instr[6:0] != OP_LOAD || f3 == 3'd3 || f3 >= 3'd6)
            return 1'b0;
        addr = arch_regs[it.instr[19:15]] + {{20{it.instr[31]}}, it.instr[31:20]};
        n = access_bytes(f3);
        if (!fits(addr, n))
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (!mem_known[addr + i])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic retire_t execute_item(item_t it);
        retire_t     r;
        logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, addr, val, nxt;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic        alt, wr, st, taken;
        logic [1:0]  err;
        int          n;
        ins   = it.instr;
        rd    = ins[11:7];
        f3    = ins[14:12];
        a     = arch_regs[ins[19:15]];
        b     = arch_regs[ins[24:20]];
        alt   = ins[30];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        nxt = arch_pc + 32'd4;
        val = '0;
        wr  = 1'b0;
        st  = 1'b0;
        err = ERR_NONE;
        if (it.cmd == CMD_PRELOAD) begin
            nxt = arch_pc;
            if (fits({20'd0, it.addr}, 4)) begin
                for (int i = 0; i < 4; i++) begin
                    arch_mem[it.addr + i]  = it.data[8*i +: 8];
                    mem_known[it.addr + i] = 1'b1;
                end
                st = 1'b1;
            end
            else
                err = ERR_RANGE;
        end
        else begin
            case (ins[6:0])
                OP_REG, OP_IMM:
                begin
                    logic [31:0] y;
                    logic        sub_sra;
                    wr = 1'b1;
                    y  = (ins[6:0] == OP_REG) ? b : imm_i;
                    // immediate form only honors bit 30 on shifts
                    sub_sra = alt && (ins[6:0] == OP_REG || f3 == 3'd5);
                    case (f3)
                        3'd0: val = sub_sra ? a - y : a + y;
                        3'd1: val = a << y[4:0];
                        3'd2: val = ($signed(a) < $signed(y)) ? 32'd1 : 32'd0;
                        3'd3: val = (a < y) ? 32'd1 : 32'd0;
                        3'd4: val = a ^ y;
                        3'd5: val = sub_sra ? 32'($signed(a) >>> y[4:0]) : a >> y[4:0];
                        3'd6: val = a | y;
                        default: val = a & y;
                    endcase
                end
                OP_LUI:   begin wr = 1'b1; val = {ins[31:12], 12'd0}; end
                OP_AUIPC: begin wr = 1'b1; val = arch_pc + {ins[31:12], 12'd0}; end
                OP_JAL:   begin wr = 1'b1; val = arch_pc + 32'd4; nxt = arch_pc + imm_j; end
                OP_JALR:
                begin
                    wr  = 1'b1;
                    val = arch_pc + 32'd4;
                    nxt = (a + imm_i) & 32'hFFFF_FFFE;
                end
                OP_BRANCH:
                begin
                    case (f3)
                        3'd0: taken = a == b;
                        3'd1: taken = a != b;
                        3'd4: taken = $signed(a) < $signed(b);
                        3'd5: taken = $signed(a) >= $signed(b);
                        3'd6: taken = a < b;
                        3'd7: taken = a >= b;
                        default: taken = 1'b0;
                    endcase
                    if (taken)
                        nxt = arch_pc + imm_b;
                end
                OP_LOAD:
                begin
                    addr = a + imm_i;
                    n = access_bytes(f3);
                    if (!(f3 == 3'd3 || f3 >= 3'd6)) begin
                        if (!fits(addr, n))
                            err = ERR_RANGE;
                        else begin
                            for (int i = 0; i < n; i++)
                                val[8*i +: 8] = arch_mem[addr + i];
                            if (f3 == 3'd0)
                                val = {{24{val[7]}}, val[7:0]};
                            else if (f3 == 3'd1)
                                val = {{16{val[15]}}, val[15:0]};
                            wr = 1'b1;
                        end
                    end
                end
                OP_STORE:
                begin
                    addr = a + imm_s;
                    n = (f3 == 3'd0) ? 1 : ((f3 == 3'd1) ? 2 : 4);
                    if (f3 <= 3'd2) begin
                        if (!fits(addr, n))
                            err = ERR_RANGE;
                        else begin
                            for (int i = 0; i < n; i++) begin
                                arch_mem[addr + i]  = b[8*i +: 8];
                                mem_known[addr + i] = 1'b1;
                            end
                            st = 1'b1;
                        end
                    end
                end
                OP_FENCE, OP_SYSTEM: ;
                default: err = ERR_OPCODE;
            endcase
            if (err != ERR_NONE) begin
                nxt = arch_pc;
                wr  = 1'b0;
            end
            if (rd == 5'd0)
                wr = 1'b0;
            if (wr)
                arch_regs[rd] = val;
            arch_pc = nxt;
        end
        r.pc_next    = nxt;
        r.rd_index   = wr ? rd : 5'd0;
        r.rd_value   = wr ? val : 32'd0;
        r.rd_written = wr;
        r.store_done = st;
        r.error      = err;
        return r;
    endfunction

    // ---------------- random item source ----------------
    function automatic item_t random_item();
        item_t       it;
        int          k, target;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [31:0] off;
        logic [6:0]  op;
        k   = $urandom_range(99);
        rd  = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        f3  = 3'($urandom);
        it.cmd   = CMD_EXEC;
        it.instr = $urandom;
        it.addr  = 12'($urandom);   // junk on execute items
        it.data  = $urandom;
        if (k < 8) begin
            it.cmd = CMD_PRELOAD;
            if (k < 2)
                it.addr = 12'($urandom_range(4088, 4095));
        end
        else if (k < 23) begin
            target = $urandom_range(0, 300);
            off = 32'(target) - arch_regs[rs1];
            if ($urandom_range(3) != 0 || !($signed(off) >= -2048 && $signed(off) < 2048)) begin
                rs1 = 5'd0;
                off = 32'(target);
            end
            if ($urandom_range(7) == 0)
                off = 32'($urandom);
            it.instr = enc_i(OP_LOAD, rd, f3, rs1, off[11:0]);
        end
        else if (k < 35) begin
            if ($urandom_range(3) == 0)
                it.instr = enc_s(f3, rs1, rs2, 12'($urandom));
            else
                it.instr = enc_s(f3, 5'd0, rs2, 12'($urandom_range(0, 2047)));
        end
        else if (k < 55)
            it.instr = enc_r(OP_REG, rd, f3, rs1, rs2,
                             ($urandom_range(3) == 0) ? 7'($urandom) :
                             ($urandom_range(1) ? 7'h20 : 7'h00));
        else if (k < 72)
            it.instr = enc_i(OP_IMM, rd, f3, ($urandom_range(2) == 0) ? 5'd0 : rs1,
                             12'($urandom));
        else if (k < 76)
            it.instr = enc_u(OP_LUI, rd, 20'($urandom));
        else if (k < 80)
            it.instr = enc_u(OP_AUIPC, rd, 20'($urandom));
        else if (k < 84)
            it.instr = enc_j(rd, 21'($urandom));
        else if (k < 88)
            it.instr = enc_i(OP_JALR, rd, f3, rs1, 12'($urandom));
        else if (k < 95)
            it.instr = enc_b(f3, rs1, ($urandom_range(3) == 0) ? rs1 : rs2, 13'($urandom));
        else if (k < 96)
            it.instr = {it.instr[31:7], OP_FENCE};
        else if (k < 97)
            it.instr = {it.instr[31:7], OP_SYSTEM};
        else if (k < 98) begin
            do
                op = 7'($urandom);
            while (op inside {OP_REG, OP_IMM, OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
                              OP_BRANCH, OP_LOAD, OP_STORE, OP_FENCE, OP_SYSTEM});
            it.instr = {it.instr[31:7], op};
        end
        return it;
    endfunction

    // ---------------- stimulus side ----------------
    task automatic send_item(item_t it, logic typed, retire_t res);
        retire_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        predicted = execute_item(it);
        pending_results.push_back(typed ? res : predicted);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {4'd0, it.data, it.addr, it.instr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain_and_configure(logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we  <= 1'b0;
        arch_pc = value;
    endtask

    task automatic add_row(item_t it, logic typed = 1'b0, logic [31:0] pc = '0,
                           logic [4:0] rd = '0, logic [31:0] v = '0, logic st = 1'b0,
                           logic [1:0] err = ERR_NONE);
        row_t row;
        row.it  = it;
        row.typed = typed;
        row.res = '{pc, rd, v, rd != 5'd0, st, err};
        directed_rows.push_back(row);
    endtask

    function automatic item_t exe(logic [31:0] ins);
        return '{CMD_EXEC, ins, 12'hABC, 32'h5A5A_C3C3};
    endfunction

    function automatic item_t pre(logic [11:0] addr, logic [31:0] data);
        return '{CMD_PRELOAD, $urandom, addr, data};
    endfunction

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        retire_t exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end
            else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.pc_next) begin
                    $error("pc_next exp %h got %h", exp_r.pc_next, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[36:32] !== exp_r.rd_index) begin
                    $error("rd_index exp %0d got %0d", exp_r.rd_index, m_axis_tdata[36:32]);
                    errors++;
                end
                if (m_axis_tdata[68:37] !== exp_r.rd_value) begin
                    $error("rd_value exp %h got %h", exp_r.rd_value, m_axis_tdata[68:37]);
                    errors++;
                end
                if (m_axis_tdata[69] !== exp_r.rd_written) begin
                    $error("rd_written exp %b got %b", exp_r.rd_written, m_axis_tdata[69]);
                    errors++;
                end
                if (m_axis_tdata[70] !== exp_r.store_done) begin
                    $error("store_done exp %b got %b", exp_r.store_done, m_axis_tdata[70]);
                    errors++;
                end
                if (m_axis_tdata[72:71] !== exp_r.error) begin
                    $error("error exp %0d got %0d", exp_r.error, m_axis_tdata[72:71]);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        item_t       it;
        logic [31:0] start_vals [4];
        int          idle_modes [4][2];
        start_vals = '{32'h0, 32'hFFFF_FFFC, 32'hFFFF_FFFF, $urandom};
        idle_modes = '{'{0, 0}, '{66, 0}, '{0, 66}, '{22, 22}};
        arch_pc = '0;
        for (int i = 0; i < 32; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++) begin
            arch_mem[i]  = '0;
            mem_known[i] = 1'b0;
        end

        add_row(pre(12'd0, 32'h80FF_7F01), 1'b1, 32'd0, 5'd0, 32'd0, 1'b1);
        add_row(pre(12'd4092, 32'hA5A5_A5A5), 1'b1, 32'd0, 5'd0, 32'd0, 1'b1);
        add_row(pre(12'd4095, 32'hFFFF_FFFF), 1'b1, 32'd0, 5'd0, 32'd0, 1'b0, ERR_RANGE);
        add_row(exe(32'h0), 1'b1, 32'd0, 5'd0, 32'd0, 1'b0, ERR_OPCODE);
        add_row(exe(32'hFFFF_FFFF), 1'b1, 32'd0, 5'd0, 32'd0, 1'b0, ERR_OPCODE);
        add_row(exe(enc_i(OP_IMM, 5'd1, 3'd0, 5'd0, 12'hFFF)), 1'b1, 32'd4, 5'd1,
                32'hFFFF_FFFF);
        add_row(exe(enc_i(OP_IMM, 5'd0, 3'd0, 5'd0, 12'd5)), 1'b1, 32'd8);
        add_row(exe(enc_i(OP_LOAD, 5'd2, 3'd0, 5'd0, 12'd0)));      // lb
        add_row(exe(enc_i(OP_LOAD, 5'd3, 3'd4, 5'd0, 12'd3)));      // lbu
        add_row(exe(enc_i(OP_LOAD, 5'd4, 3'd1, 5'd0, 12'd2)));      // lh
        add_row(exe(enc_i(OP_LOAD, 5'd5, 3'd5, 5'd0, 12'd2)));      // lhu
        add_row(exe(enc_i(OP_LOAD, 5'd6, 3'd2, 5'd0, 12'd0)));      // lw
        add_row(exe(enc_i(OP_LOAD, 5'd7, 3'd2, 5'd0, 12'hFFC)));    // wraps, out of range
        add_row(exe(enc_i(OP_LOAD, 5'd7, 3'd3, 5'd0, 12'd0)));      // unused load width
        add_row(exe(enc_s(3'd2, 5'd0, 5'd1, 12'd8)));
        add_row(exe(enc_s(3'd0, 5'd0, 5'd1, 12'hFFF)));             // sb out of range
        add_row(exe(enc_s(3'd3, 5'd0, 5'd1, 12'd16)));              // unused store width
        add_row(exe(enc_r(OP_REG, 5'd8, 3'd0, 5'd0, 5'd1, 7'h20))); // sub
        add_row(exe(enc_i(OP_IMM, 5'd9, 3'd5, 5'd1, 12'h41F)));     // srai 31
        add_row(exe(enc_i(OP_IMM, 5'd10, 3'd1, 5'd1, 12'h03F)));    // shamt bit 5 ignored
        add_row(exe(enc_r(OP_REG, 5'd11, 3'd2, 5'd1, 5'd0, 7'h00)));
        add_row(exe(enc_r(OP_REG, 5'd12, 3'd3, 5'd1, 5'd0, 7'h00)));
        add_row(exe(enc_u(OP_LUI, 5'd13, 20'hFFFFF)));
        add_row(exe(enc_u(OP_AUIPC, 5'd14, 20'h00001)));
        add_row(exe(enc_b(3'd0, 5'd0, 5'd0, 13'd8)));
        add_row(exe(enc_b(3'd2, 5'd0, 5'd0, 13'd8)));               // unused branch kind
        add_row(exe(enc_j(5'd15, 21'h1FFFF8)));
        add_row(exe(enc_i(OP_JALR, 5'd16, 3'd0, 5'd1, 12'd0)));
        add_row(exe({25'h0, OP_FENCE}));
        add_row(exe({25'h0, OP_SYSTEM}));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        // fill a window that the load streams can read back
        for (int a = 0; a < 320; a += 4)
            send_item(pre(12'(a), $urandom), 1'b0, '{default: '0});

        for (int phase = 0; phase < 4; phase++) begin
            drain_and_configure(start_vals[phase]);
            send_idle_pct  = idle_modes[phase][0];
            sink_stall_pct = idle_modes[phase][1];
            for (int n = 0; n < 365; n++) begin
                do
                    it = random_item();
                while (touches_unknown(it));
                if (n % 100 > 80)   // stretch with no idling at all
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                else
                begin
                    send_idle_pct  = idle_modes[phase][0];
                    sink_stall_pct = idle_modes[phase][1];
                end
                send_item(it, 1'b0, '{default: '0});
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/rv32_pkg.sv
src/rv32_exec.sv
src/rv32_state.sv
src/rv32i_execute_core_unit.sv
tb/testbench.sv
